@@ rtl/brf_pkg.sv @@
// ============================================================================
// Byte ring FIFO package
// Shared types, sizes and helper functions for the byte ring FIFO block.
// ============================================================================
package brf_pkg;

  // Physical size of the byte store.
  localparam int DEPTH   = 64;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int SLOT_W  = $clog2(DEPTH + 1);

  // Fixed field widths of the channels.
  localparam int OP_W    = 2;
  localparam int BYTE_W  = 8;
  localparam int FREE_W  = 6;
  localparam int CFG_W   = 7;

  // Command queue between front and back end.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_W-1:0] SLOTS_RESET = CFG_W'(64);
  localparam logic [CFG_W-1:0] SLOTS_MIN   = CFG_W'(2);

  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_GET   = 2'd1,
    OP_DRAIN = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    B_IDLE,
    B_READ
  } back_state_e;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [BYTE_W-1:0] put_byte;
  } req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    status_e           status;
    logic [FREE_W-1:0] free_slots;
    logic              last;
  } rsp_t;

  typedef struct packed {
    op_e               op;
    logic [BYTE_W-1:0] data;
  } cmd_t;

  // Advance a ring index, wrapping at the configured slot count.
  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0]  idx,
                                                input logic [SLOT_W-1:0] slots);
    logic [SLOT_W-1:0] n;
    n = SLOT_W'(idx) + SLOT_W'(1);
    return (n == slots) ? '0 : n[IDX_W-1:0];
  endfunction

  // Bring a written slot count into the supported range.
  function automatic logic [SLOT_W-1:0] clamp_slots(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] s;
    s = v;
    if (s < SLOTS_MIN) begin
      s = SLOTS_MIN;
    end
    if (s > CFG_W'(DEPTH)) begin
      s = CFG_W'(DEPTH);
    end
    return SLOT_W'(s);
  endfunction

endpackage

@@ rtl/byte_ring_fifo.sv @@
// ============================================================================
// Byte ring FIFO
// Circular byte FIFO with put, get and drain requests and a slot-count
// register.
// ============================================================================
// Usage: a request on req carries an operation (put, get or drain) and a
// byte. Each put and get gives exactly one response on rsp; a drain gives
// one response per stored byte, oldest first, with last set on the final
// one, and nothing when the FIFO is empty. Operation code 3 is dropped.
// Every response reports the free count after its own effect.
// The request is registered by the front end, passes a two-entry command
// queue and is executed by the back end, which owns the byte store and the
// response register. A get that reads a byte also waits on the store read,
// which is registered. While rsp_ready is high, puts sustain one request per
// cycle; a get that reads the store holds the back end in its read state,
// where it takes no new command; a drain streams one byte per cycle after
// its first read. When rsp_ready is low the response register holds, the
// back end stops and the queue fills, after which req_ready falls. A
// cfg_data write sets the slot count (clamped to 2..64) and empties the
// FIFO; the user must make it only while the block is idle, as the block
// does not enforce this. Reset empties the FIFO and selects 64 slots.
// ============================================================================
module byte_ring_fifo import brf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  req_t             req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output rsp_t             rsp,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  logic cmd_in_valid;
  logic cmd_in_ready;
  cmd_t cmd_in;
  logic cmd_out_valid;
  logic cmd_out_ready;
  cmd_t cmd_out;

  // The register is always writable; the user must write it only while idle.
  assign cfg_ready = 1'b1;

  brf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .cmd_valid (cmd_in_valid),
    .cmd_ready (cmd_in_ready),
    .cmd       (cmd_in)
  );

  brf_cmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (cmd_in_valid),
    .push_ready (cmd_in_ready),
    .push_cmd   (cmd_in),
    .pop_valid  (cmd_out_valid),
    .pop_ready  (cmd_out_ready),
    .pop_cmd    (cmd_out)
  );

  brf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_out_valid),
    .cmd_ready (cmd_out_ready),
    .cmd       (cmd_out),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

@@ rtl/brf_front.sv @@
// ============================================================================
// Byte ring FIFO front end
// Registers incoming requests, drops unused operation codes and turns the
// rest into commands for the queue.
// ============================================================================
module brf_front import brf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic cmd_valid,
  input  logic cmd_ready,
  output cmd_t cmd
);

  logic hold_valid;
  req_t hold;
  logic is_cmd;
  logic hold_done;

  // Operation code 3 carries no work and is dropped here.
  assign is_cmd    = (hold.operation == OP_PUT) || (hold.operation == OP_GET) ||
                     (hold.operation == OP_DRAIN);
  assign hold_done = hold_valid && (!is_cmd || cmd_ready);
  assign req_ready = !hold_valid || hold_done;

  assign cmd_valid = hold_valid && is_cmd;
  assign cmd.op    = op_e'(hold.operation);
  assign cmd.data  = hold.put_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (req_ready) begin
      hold_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      hold <= req;
    end
  end

endmodule

@@ rtl/brf_cmd_queue.sv @@
// ============================================================================
// Byte ring FIFO command queue
// Short queue that decouples the front end from the back end.
// ============================================================================
module brf_cmd_queue import brf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp;
  logic [QPTR_W-1:0] rp;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rp];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wp <= (wp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp + QPTR_W'(1);
      end
      if (do_pop) begin
        rp <= (rp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wp] <= push_cmd;
    end
  end

endmodule

@@ rtl/brf_back.sv @@
// ============================================================================
// Byte ring FIFO back end
// Owns the byte store, ring indices and fill count, executes commands and
// holds the response register.
// ============================================================================
module brf_back import brf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  cmd_t             cmd,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output rsp_t             rsp
);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata;

  back_state_e       state;
  back_state_e       state_next;
  logic [IDX_W-1:0]  wr_idx;
  logic [IDX_W-1:0]  rd_idx;
  logic [IDX_W-1:0]  fill;
  logic [SLOT_W-1:0] slots;
  logic              last_pend;
  logic              last_pend_next;

  logic              out_free;
  logic              full;
  logic              empty;
  logic [SLOT_W-1:0] free_now;
  logic              mem_we;
  logic              mem_re;
  logic              load_rsp;
  rsp_t              rsp_next;

  assign out_free = !rsp_valid || rsp_ready;
  assign full     = ((SLOT_W'(fill) + SLOT_W'(1)) == slots);
  assign empty    = (fill == '0);
  assign free_now = slots - SLOT_W'(1) - SLOT_W'(fill);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (cmd_valid && out_free && !empty &&
            (cmd.op == OP_GET || cmd.op == OP_DRAIN)) begin
          state_next = B_READ;
        end
      end
      B_READ: begin
        if (out_free && last_pend) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // Datapath controls and the response word.
  always_comb begin
    cmd_ready      = 1'b0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    load_rsp       = 1'b0;
    last_pend_next = 1'b0;
    rsp_next       = '{out_byte: '0, status: ST_OK,
                       free_slots: FREE_W'(free_now), last: 1'b1};
    unique case (state)
      B_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_ready = 1'b1;
          unique case (cmd.op)
            OP_PUT: begin
              load_rsp = 1'b1;
              if (full) begin
                rsp_next.status = ST_FULL;
              end else begin
                mem_we              = 1'b1;
                rsp_next.free_slots = FREE_W'(free_now - SLOT_W'(1));
              end
            end
            OP_GET: begin
              if (empty) begin
                load_rsp        = 1'b1;
                rsp_next.status = ST_EMPTY;
              end else begin
                mem_re         = 1'b1;
                last_pend_next = 1'b1;
              end
            end
            OP_DRAIN: begin
              // An empty drain retires without a response.
              if (!empty) begin
                mem_re         = 1'b1;
                last_pend_next = (fill == IDX_W'(1));
              end
            end
            default: ;
          endcase
        end
      end
      B_READ: begin
        if (out_free) begin
          load_rsp          = 1'b1;
          rsp_next.out_byte = rdata;
          rsp_next.last     = last_pend;
          // Keep draining: fetch the next byte while this one goes out.
          if (!last_pend) begin
            mem_re         = 1'b1;
            last_pend_next = (fill == IDX_W'(1));
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      wr_idx    <= '0;
      rd_idx    <= '0;
      fill      <= '0;
      slots     <= clamp_slots(SLOTS_RESET);
      last_pend <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        slots  <= clamp_slots(cfg_data);
        wr_idx <= '0;
        rd_idx <= '0;
        fill   <= '0;
      end else begin
        if (mem_we) begin
          wr_idx <= next_idx(wr_idx, slots);
          fill   <= fill + IDX_W'(1);
        end
        if (mem_re) begin
          rd_idx    <= next_idx(rd_idx, slots);
          fill      <= fill - IDX_W'(1);
          last_pend <= last_pend_next;
        end
      end
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_idx] <= cmd.data;
    end
    if (mem_re) begin
      rdata <= mem[rd_idx];
    end
  end

endmodule

@@ test/byte_ring_fifo_tb.sv @@
// ============================================================================
// Byte ring FIFO testbench
// Sends put, get and drain requests through the valid/ready request channel
// and checks every response, field by field, against a ring buffer model
// kept inside this bench. A short scripted sequence covers the edge cases.
// Randomized phases follow; each one starts with a slot-count write.
// ============================================================================
`timescale 1ns / 100ps

module byte_ring_fifo_tb import brf_pkg::*;;

  // The request channel has no name for code 3. The block drops it.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // Timing of the bench, in clock cycles, and its item and report limits.
  localparam int RESET_CYCLES = 12;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD = 300;     // one long response stall, to back up the block
  localparam int ITEM_TARGET = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_LIMIT = 10;

  typedef enum logic {
    ROW_REQ,
    ROW_CFG
  } row_kind_e;

  typedef enum int {
    STYLE_FILL,
    STYLE_MIXED,
    STYLE_NOISE
  } phase_style_e;

  // One line of the scripted sequence. A request row may give its response in
  // full (typed set). Otherwise the ring model works out the response.
  typedef struct packed {
    row_kind_e          kind;
    logic [CFG_W-1:0]   slots;
    logic [OP_W-1:0]    op;
    logic [BYTE_W-1:0]  data;
    logic               typed;
    rsp_t               result;
  } script_row_t;

  localparam int SCRIPT_LEN = 29;

  // The sequence starts at the reset slot count of 64. It then visits the
  // smallest size, a write below range, a write above range and a size of
  // three, where a put into a full FIFO is rejected.
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    // kind     slots  op         data   typed  out_byte status    free   last
    '{ROW_REQ, 7'd0,   OP_GET,    8'h00, 1'b1, '{8'h00, ST_EMPTY, 6'd63, 1'b1}},
    '{ROW_REQ, 7'd0,   OP_DRAIN,  8'h00, 1'b0, '0},
    '{ROW_REQ, 7'd0,   OP_UNUSED, 8'hFF, 1'b0, '0},
    '{ROW_REQ, 7'd0,   OP_PUT,    8'h00, 1'b1, '{8'h00, ST_OK,    6'd62, 1'b1}},
    '{ROW_REQ, 7'd0,   OP_PUT,    8'hFF, 1'b1, '{8'h00, ST_OK,    6'd61, 1'b1}},
    '{ROW_REQ, 7'd0,   OP_GET,    8'h00, 1'b1, '{8'h00, ST_OK,    6'd62, 1'b1}},
    '{ROW_REQ, 7'd0,   OP_DRAIN,  8'h00, 1'b1, '{8'hFF, ST_OK,    6'd63, 1'b1}},
    '{ROW_CFG, 7'd2,   OP_PUT,    8'h00, 1'b0, '0},
    '{ROW_REQ, 7'd0,   OP_PUT,    8'hA5, 1'b1, '{8'h00, ST_OK,    6'd0,  1'b1}},
    '{ROW_REQ, 7'd0,   OP_PUT,    8'h5A, 1'b1, '{8'h00, ST_FULL,  6'd0,  1'b1}},
    '{ROW_REQ, 7'd0,   OP_GET,    8'h00, 1'b1, '{8'hA5, ST_OK,    6'd1,  1'b1}},
    '{ROW_REQ, 7'd0,   OP_GET,    8'h00, 1'b1, '{8'h00, ST_EMPTY, 6'd1,  1'b1}},
    '{ROW_REQ, 7'd0,   OP_PUT,    8'h3C, 1'b0, '0},
    '{ROW_CFG, 7'd0,   OP_PUT,    8'h00, 1'b0, '0},
    '{ROW_REQ, 7'd0,   OP_GET,    8'h00, 1'b1, '{8'h00, ST_EMPTY, 6'd1,  1'b1}},
    '{ROW_REQ, 7'd0,   OP_PUT,    8'hC3, 1'b0, '0},
    '{ROW_REQ, 7'd0,   OP_PUT,    8'h11, 1'b1, '{8'h00, ST_FULL,  6'd0,  1'b1}},
    '{ROW_CFG, 7'd127, OP_PUT,    8'h00, 1'b0, '0},
    '{ROW_REQ, 7'd0,   OP_GET,    8'h00, 1'b1, '{8'h00, ST_EMPTY, 6'd63, 1'b1}},
    '{ROW_REQ, 7'd0,   OP_PUT,    8'h81, 1'b0, '0},
    '{ROW_REQ, 7'd0,   OP_PUT,    8'h7E, 1'b0, '0},
    '{ROW_REQ, 7'd0,   OP_PUT,    8'h55, 1'b0, '0},
    '{ROW_REQ, 7'd0,   OP_DRAIN,  8'h00, 1'b0, '0},
    '{ROW_CFG, 7'd3,   OP_PUT,    8'h00, 1'b0, '0},
    '{ROW_REQ, 7'd0,   OP_PUT,    8'h01, 1'b0, '0},
    '{ROW_REQ, 7'd0,   OP_PUT,    8'h02, 1'b0, '0},
    '{ROW_REQ, 7'd0,   OP_PUT,    8'h03, 1'b1, '{8'h00, ST_FULL,  6'd0,  1'b1}},
    '{ROW_REQ, 7'd0,   OP_GET,    8'h00, 1'b0, '0},
    '{ROW_REQ, 7'd0,   OP_DRAIN,  8'h00, 1'b0, '0}
  };

  logic             clk;
  logic             rst;
  logic             req_valid;
  logic             req_ready;
  req_t             req;
  logic             rsp_valid;
  logic             rsp_ready;
  rsp_t             rsp;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data;

  // The bench's own ring buffer, updated when a request is accepted.
  logic [BYTE_W-1:0] ring_bytes [DEPTH];
  int unsigned       ring_wr;
  int unsigned       ring_rd;
  int unsigned       ring_slots;

  rsp_t rsp_owed [$];       // responses the block still owes, oldest first
  rsp_t step_rsp [$];       // responses caused by the request just accepted
  int   bad_rsp_count = 0;
  int   cycle_count = 0;
  int   hold_asks = 0;      // raised by the request side to ask for a long stall
  int   send_calm = 0;
  int   items_sent = 0;

  byte_ring_fifo dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Gap lengths for both sides. Most gaps are zero or short and a few are
  // long. Now and then a calm stretch runs with no gaps at all.
  function automatic int pick_gap(inout int calm);
    int roll;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (roll < 60) return 0;
    if (roll < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned ring_next(input int unsigned idx);
    return (idx + 1 >= ring_slots) ? 0 : idx + 1;
  endfunction

  // One slot always stays empty, so a full ring has ring_slots - 1 entries.
  function automatic int unsigned ring_free();
    if (ring_wr >= ring_rd) return ring_slots - 1 - (ring_wr - ring_rd);
    return ring_rd - ring_wr - 1;
  endfunction

  function automatic rsp_t ring_rsp(input logic [BYTE_W-1:0] b, input status_e st,
                                    input logic fin);
    rsp_t res;
    res.out_byte = b;
    res.status = st;
    res.free_slots = FREE_W'(ring_free());
    res.last = fin;
    return res;
  endfunction

  // Apply one request to the ring and collect the responses it causes in
  // step_rsp. A drain gives one response per stored byte and marks the
  // last one. A drain of an empty ring gives none, and code 3 changes nothing.
  function automatic void ring_apply(input req_t r);
    logic [BYTE_W-1:0] b;
    step_rsp.delete();
    if (r.operation == OP_PUT) begin
      if (ring_next(ring_wr) != ring_rd) begin
        ring_bytes[IDX_W'(ring_wr)] = r.put_byte;
        ring_wr = ring_next(ring_wr);
        step_rsp.push_back(ring_rsp('0, ST_OK, 1'b1));
      end else begin
        step_rsp.push_back(ring_rsp('0, ST_FULL, 1'b1));
      end
    end else if (r.operation == OP_GET) begin
      if (ring_wr != ring_rd) begin
        b = ring_bytes[IDX_W'(ring_rd)];
        ring_rd = ring_next(ring_rd);
        step_rsp.push_back(ring_rsp(b, ST_OK, 1'b1));
      end else begin
        step_rsp.push_back(ring_rsp('0, ST_EMPTY, 1'b1));
      end
    end else if (r.operation == OP_DRAIN) begin
      while (ring_wr != ring_rd) begin
        b = ring_bytes[IDX_W'(ring_rd)];
        ring_rd = ring_next(ring_rd);
        step_rsp.push_back(ring_rsp(b, ST_OK, ring_wr == ring_rd));
      end
    end
  endfunction

  // Offer one request after a random gap and hold it until it is taken.
  // Valid is lowered only during a gap. Between two requests sent back to
  // back it stays high and only the payload changes.
  task automatic push_request(input req_t r, input logic typed, input rsp_t typed_rsp);
    int gap;
    gap = pick_gap(send_calm);
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    ring_apply(r);
    if (typed) begin
      rsp_owed.push_back(typed_rsp);
    end else begin
      foreach (step_rsp[i]) rsp_owed.push_back(step_rsp[i]);
    end
  endtask

  task automatic offer(input logic [OP_W-1:0] op);
    req_t r;
    r.operation = op;
    r.put_byte = BYTE_W'($urandom_range(0, 255));
    if (op != OP_UNUSED) items_sent++;
    push_request(r, 1'b0, '0);
  endtask

  // The slot count is written only while the block is idle. The bench waits
  // until every owed response has arrived. It then waits out the settle time,
  // since an empty drain or an unused code may still be in flight. The
  // write empties the ring.
  task automatic load_slots(input logic [CFG_W-1:0] v);
    @(negedge clk);
    req_valid <= 1'b0;
    while (rsp_owed.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (v < 2) ring_slots = 2;
    else if (v > DEPTH) ring_slots = DEPTH;
    else ring_slots = 32'(v);
    ring_wr = 0;
    ring_rd = 0;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One random phase: a new slot count, then requests in one of three
  // styles. A fill phase fills the ring to full or past and drains it. It
  // then puts more bytes, so the indices wrap, and drains again. A mixed
  // phase sends a weighted mix of requests. A noise phase sends any code.
  task automatic run_phase(input logic squeeze);
    logic [CFG_W-1:0]  slots_code;
    logic [OP_W-1:0]   op;
    phase_style_e      style;
    int                roll;
    int                span;
    int                cap;
    int                k;
    roll = $urandom_range(0, 5);
    case (roll)
      0: begin
        slots_code = SLOTS_MIN;
      end
      1: begin
        slots_code = CFG_W'(DEPTH);
      end
      2: begin
        slots_code = CFG_W'($urandom_range(0, 127));
      end
      default: begin
        slots_code = CFG_W'($urandom_range(3, 12));
      end
    endcase
    if (squeeze) slots_code = CFG_W'(DEPTH);
    load_slots(slots_code);
    cap = ring_slots - 1;
    roll = $urandom_range(0, 19);
    if (squeeze || roll < 8) style = STYLE_FILL;
    else if (roll < 17) style = STYLE_MIXED;
    else style = STYLE_NOISE;
    case (style)
      STYLE_FILL: begin
        // For the squeeze, the response side stalls for a long time while
        // puts keep coming. The block backs up and stops taking requests.
        if (squeeze) hold_asks++;
        span = cap + $urandom_range(0, 2);
        for (k = 0; k < span; k++) offer(OP_PUT);
        if ($urandom_range(0, 2) == 0) begin
          for (k = 0; k < cap / 2; k++) offer(OP_GET);
        end
        offer(OP_DRAIN);
        span = $urandom_range(1, cap);
        for (k = 0; k < span; k++) offer(OP_PUT);
        offer(OP_DRAIN);
        if ($urandom_range(0, 3) == 0) offer(OP_GET);
      end
      STYLE_MIXED: begin
        span = $urandom_range(20, 40);
        for (k = 0; k < span; k++) begin
          roll = $urandom_range(0, 99);
          if (roll < 45) op = OP_PUT;
          else if (roll < 80) op = OP_GET;
          else if (roll < 95) op = OP_DRAIN;
          else op = OP_UNUSED;
          offer(op);
        end
      end
      default: begin
        span = $urandom_range(6, 15);
        for (k = 0; k < span; k++) offer(OP_W'($urandom_range(0, 3)));
      end
    endcase
  endtask

  // Request side: reset, the scripted sequence, then random phases until
  // enough requests have gone in. Then wait for every owed response.
  initial begin : request_side
    req_t r;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    ring_wr = 0;
    ring_rd = 0;
    ring_slots = DEPTH;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < SCRIPT_LEN; i++) begin
      if (SCRIPT[i].kind == ROW_CFG) begin
        load_slots(SCRIPT[i].slots);
      end else begin
        r.operation = SCRIPT[i].op;
        r.put_byte = SCRIPT[i].data;
        push_request(r, SCRIPT[i].typed, SCRIPT[i].result);
      end
    end

    run_phase(1'b1);
    while (items_sent < ITEM_TARGET) run_phase(1'b0);

    @(negedge clk);
    req_valid <= 1'b0;
    while (rsp_owed.size() != 0) @(posedge clk);
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (bad_rsp_count == 0) begin
      $display("byte_ring_fifo regression: pass");
    end else begin
      $display("byte_ring_fifo regression: fail");
    end
    $finish;
  end

  // Response side: random stalls of rsp_ready. When the request side asks,
  // it also holds one long stall, counted here.
  initial begin : response_side
    int stall_left;
    int calm_left;
    int hold_done;
    int gap;
    stall_left = 0;
    calm_left = 0;
    hold_done = 0;
    rsp_ready = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_done != hold_asks) begin
        hold_done = hold_asks;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        rsp_ready <= 1'b0;
        stall_left--;
      end else begin
        gap = pick_gap(calm_left);
        if (gap > 0) begin
          rsp_ready <= 1'b0;
          stall_left = gap - 1;
        end else begin
          rsp_ready <= 1'b1;
        end
      end
    end
  end

  function automatic void flag_error(input string msg);
    bad_rsp_count++;
    if (bad_rsp_count <= REPORT_LIMIT) $display("%0t ns: %s", $realtime, msg);
  endfunction

  // Compare each accepted response with the oldest owed one.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (rsp_owed.size() == 0) begin
        flag_error($sformatf("response with none owed: byte %02h st %0d free %0d last %0b",
                             rsp.out_byte, rsp.status, rsp.free_slots, rsp.last));
      end else begin
        want = rsp_owed.pop_front();
        if (rsp.out_byte !== want.out_byte || rsp.status !== want.status ||
            rsp.free_slots !== want.free_slots || rsp.last !== want.last) begin
          flag_error($sformatf({"response mismatch: want byte %02h st %0d free %0d last %0b,",
                                " got byte %02h st %0d free %0d last %0b"},
                               want.out_byte, want.status, want.free_slots, want.last,
                               rsp.out_byte, rsp.status, rsp.free_slots, rsp.last));
        end
      end
    end
  end

  // A hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("byte_ring_fifo regression: fail");
      $finish;
    end
  end

endmodule
